/* rtl/core/ebip_pkg.sv */
// Shared types, constants and lookup functions for the encoder, button and idle-power unit.
package ebip_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int IDLE_WIDTH  = 19;
    localparam int SINCE_WIDTH = 8;
    localparam int PRESET_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLEEP_PRESET = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_MS  = CFG_INDEX_WIDTH'(1);

    localparam logic [SINCE_WIDTH-1:0] DEBOUNCE_RESET = SINCE_WIDTH'(20);
    localparam logic [IDLE_WIDTH-1:0]  IDLE_MAX = {IDLE_WIDTH{1'b1}};

    localparam logic [PRESET_WIDTH-1:0] PRESET_OFF  = PRESET_WIDTH'(0);
    localparam logic [PRESET_WIDTH-1:0] PRESET_30S  = PRESET_WIDTH'(1);
    localparam logic [PRESET_WIDTH-1:0] PRESET_1MIN = PRESET_WIDTH'(2);
    localparam logic [PRESET_WIDTH-1:0] PRESET_2MIN = PRESET_WIDTH'(3);
    localparam logic [PRESET_WIDTH-1:0] PRESET_5MIN = PRESET_WIDTH'(4);

    typedef struct packed {
        logic enc_a;
        logic enc_b;
        logic knob_key_down;
        logic user_key_down;
        logic ms_tick;
    } in_t;

    typedef struct packed {
        logic signed [1:0] detent_step;
        logic              knob_press_event;
        logic              user_press_event;
        logic              knob_held;
        logic              user_held;
        logic              backlight_dim;
        logic              sleep_request;
    } out_t;

    // Count change for a move from the previous A/B pair to the current one.
    function automatic logic signed [1:0] quad_step(input logic [1:0] prev_ab,
                                                    input logic [1:0] cur_ab);
        logic signed [1:0] step;
        unique case ({prev_ab, cur_ab})
            4'b0001: step = -2'sd1;
            4'b0010: step = 2'sd1;
            4'b0100: step = 2'sd1;
            4'b0111: step = -2'sd1;
            4'b1000: step = -2'sd1;
            4'b1011: step = 2'sd1;
            4'b1101: step = 2'sd1;
            4'b1110: step = -2'sd1;
            default: step = 2'sd0;
        endcase
        return step;
    endfunction

    // Sleep timeout in ms; zero means sleep is off.
    function automatic logic [IDLE_WIDTH-1:0] sleep_time(input logic [PRESET_WIDTH-1:0] preset);
        logic [IDLE_WIDTH-1:0] t;
        unique case (preset)
            PRESET_30S:  t = IDLE_WIDTH'(30000);
            PRESET_1MIN: t = IDLE_WIDTH'(60000);
            PRESET_2MIN: t = IDLE_WIDTH'(120000);
            PRESET_5MIN: t = IDLE_WIDTH'(300000);
            default:     t = '0;
        endcase
        return t;
    endfunction

    // Dim time in ms: two thirds of the sleep time.
    function automatic logic [IDLE_WIDTH-1:0] dim_time(input logic [PRESET_WIDTH-1:0] preset);
        logic [IDLE_WIDTH-1:0] t;
        unique case (preset)
            PRESET_30S:  t = IDLE_WIDTH'(20000);
            PRESET_1MIN: t = IDLE_WIDTH'(40000);
            PRESET_2MIN: t = IDLE_WIDTH'(80000);
            PRESET_5MIN: t = IDLE_WIDTH'(200000);
            default:     t = '0;
        endcase
        return t;
    endfunction

endpackage

/* rtl/core/encoder_button_idle_power_unit.sv */
// Top level of the encoder, button and idle-power unit.
// A sample passes through the input register and then the result register.
// Throughput: one sample per cycle while out_ready holds; the input register, the
// per-sample logic and the result register form a two-stage pipeline.
// Reset: asynchronous, active low; counts, key levels, idle time and the dim flag clear,
// sleep_preset resets to off and debounce_ms to 20.
module encoder_button_idle_power_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  ebip_pkg::in_t                          in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output ebip_pkg::out_t                         out_data,
    input  logic                                   cfg_we,
    input  logic [ebip_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [ebip_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata
);

    // Configuration registers.
    logic [ebip_pkg::PRESET_WIDTH-1:0] sleep_preset_reg;
    logic [ebip_pkg::SINCE_WIDTH-1:0]  debounce_ms_reg;

    // Input stage.
    logic          in_valid_reg;
    ebip_pkg::in_t in_data_reg;

    // Result stage.
    logic           out_valid_reg;
    ebip_pkg::out_t out_data_reg;
    ebip_pkg::out_t out_data_next;

    // Block state.
    logic [1:0]                            prev_ab_reg;
    logic [ebip_pkg::COUNT_WIDTH-1:0]      raw_count_reg;
    logic [ebip_pkg::COUNT_WIDTH-1:0]      raw_count_next;
    logic [ebip_pkg::COUNT_WIDTH-1:0]      detent_base_reg;
    logic [ebip_pkg::COUNT_WIDTH-1:0]      detent_base_next;
    logic [ebip_pkg::IDLE_WIDTH-1:0]       idle_ms_reg;
    logic [ebip_pkg::IDLE_WIDTH-1:0]       idle_ms_next;
    logic                                  dimmed_reg;
    logic                                  dimmed_next;

    logic                                  fire;
    logic [1:0]                            cur_ab;
    logic signed [1:0]                     step;
    logic                                  moved;
    logic [ebip_pkg::COUNT_WIDTH-1:0]      diff;
    logic                                  det_up;
    logic                                  det_down;
    logic                                  tick_en;
    logic                                  knob_press;
    logic                                  user_press;
    logic                                  knob_level;
    logic                                  user_level;
    logic                                  activity;
    logic [ebip_pkg::IDLE_WIDTH-1:0]       sleep_t;
    logic [ebip_pkg::IDLE_WIDTH-1:0]       dim_t;
    logic                                  sleep_req;

    // The sample in the input register moves on whenever the result register is
    // free or its result is being taken in the same cycle. The input register in
    // turn takes a new transfer whenever it is empty or is being emptied.
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    // Configuration writes must arrive only while the unit is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_preset_reg <= ebip_pkg::PRESET_OFF;
            debounce_ms_reg  <= ebip_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ebip_pkg::REG_SLEEP_PRESET)
            begin
                sleep_preset_reg <= cfg_wdata[ebip_pkg::PRESET_WIDTH-1:0];
            end
            else if (cfg_index == ebip_pkg::REG_DEBOUNCE_MS)
            begin
                debounce_ms_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // Quadrature decode: the transition table gives -1, 0 or +1, and an invalid
    // jump where both lines change counts as no movement.
    assign cur_ab = {in_data_reg.enc_a, in_data_reg.enc_b};
    assign step   = ebip_pkg::quad_step(prev_ab_reg, cur_ab);
    assign moved  = (step != 2'sd0);
    assign raw_count_next = raw_count_reg + {{(ebip_pkg::COUNT_WIDTH-2){step[1]}}, step};

    // Detent step: the raw change since the detent base, halved toward zero.
    // It is +1 when the signed difference is at least 2 and -1 when it is at
    // most -2; the base then moves by two counts in that direction.
    assign diff     = raw_count_next - detent_base_reg;
    assign det_up   = !diff[ebip_pkg::COUNT_WIDTH-1]
                      && (diff[ebip_pkg::COUNT_WIDTH-2:1] != '0);
    assign det_down = diff[ebip_pkg::COUNT_WIDTH-1]
                      && (diff != {ebip_pkg::COUNT_WIDTH{1'b1}});

    always_comb
    begin
        detent_base_next = detent_base_reg;
        if (det_up)
        begin
            detent_base_next = detent_base_reg + ebip_pkg::COUNT_WIDTH'(2);
        end
        else if (det_down)
        begin
            detent_base_next = detent_base_reg - ebip_pkg::COUNT_WIDTH'(2);
        end
    end

    // Keys are only sampled on a millisecond tick.
    assign tick_en = fire && in_data_reg.ms_tick;

    ebip_key_debounce u_knob_key (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_en     (tick_en),
        .raw         (in_data_reg.knob_key_down),
        .debounce_ms (debounce_ms_reg),
        .press       (knob_press),
        .level       (knob_level)
    );

    ebip_key_debounce u_user_key (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_en     (tick_en),
        .raw         (in_data_reg.user_key_down),
        .debounce_ms (debounce_ms_reg),
        .press       (user_press),
        .level       (user_level)
    );

    // Idle time counts ticks and saturates; any movement or press clears it
    // together with the dim flag. With sleep off, idleness neither sets nor
    // clears the dim flag and no sleep request is raised.
    assign activity = moved || knob_press || user_press;
    assign sleep_t  = ebip_pkg::sleep_time(sleep_preset_reg);
    assign dim_t    = ebip_pkg::dim_time(sleep_preset_reg);

    always_comb
    begin
        idle_ms_next = idle_ms_reg;
        dimmed_next  = dimmed_reg;
        sleep_req    = 1'b0;
        if (in_data_reg.ms_tick && (idle_ms_reg != ebip_pkg::IDLE_MAX))
        begin
            idle_ms_next = idle_ms_reg + ebip_pkg::IDLE_WIDTH'(1);
        end
        if (activity)
        begin
            idle_ms_next = '0;
            dimmed_next  = 1'b0;
        end
        if (sleep_t != '0)
        begin
            if (idle_ms_next >= dim_t)
            begin
                dimmed_next = 1'b1;
            end
            sleep_req = (idle_ms_next >= sleep_t);
        end
    end

    always_comb
    begin
        out_data_next.detent_step      = det_up ? 2'sd1 : (det_down ? -2'sd1 : 2'sd0);
        out_data_next.knob_press_event = knob_press;
        out_data_next.user_press_event = user_press;
        out_data_next.knob_held        = knob_level;
        out_data_next.user_held        = user_level;
        out_data_next.backlight_dim    = dimmed_next;
        out_data_next.sleep_request    = sleep_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ab_reg     <= 2'b00;
            raw_count_reg   <= '0;
            detent_base_reg <= '0;
            idle_ms_reg     <= '0;
            dimmed_reg      <= 1'b0;
        end
        else if (fire)
        begin
            prev_ab_reg     <= cur_ab;
            raw_count_reg   <= raw_count_next;
            detent_base_reg <= detent_base_next;
            idle_ms_reg     <= idle_ms_next;
            dimmed_reg      <= dimmed_next;
        end
    end

    // Result register: a finished result waits here while the next sample is
    // already held in the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/ebip_key_debounce.sv */
// Time-based debouncer for one active-high key, advanced on millisecond ticks.
module ebip_key_debounce (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tick_en,
    input  logic                               raw,
    input  logic [ebip_pkg::SINCE_WIDTH-1:0]   debounce_ms,
    output logic                               press,
    output logic                               level
);

    logic                             level_reg;
    logic                             level_next;
    logic [ebip_pkg::SINCE_WIDTH-1:0] since_reg;
    logic [ebip_pkg::SINCE_WIDTH-1:0] since_next;
    logic [ebip_pkg::SINCE_WIDTH-1:0] since_inc;
    logic                             accept_change;

    // The elapsed-time counter saturates at its top value.
    assign since_inc = (since_reg == {ebip_pkg::SINCE_WIDTH{1'b1}})
                       ? since_reg : since_reg + ebip_pkg::SINCE_WIDTH'(1);
    assign accept_change = tick_en && (raw != level_reg) && (since_inc >= debounce_ms);

    always_comb
    begin
        level_next = level_reg;
        since_next = since_reg;
        if (tick_en)
        begin
            since_next = since_inc;
        end
        if (accept_change)
        begin
            level_next = raw;
            since_next = '0;
        end
    end

    assign press = accept_change && raw;
    assign level = level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            since_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            since_reg <= since_next;
        end
    end

endmodule

/* tb/sv/tb_encoder_button_idle_power_unit.sv */
// Self-checking testbench for the encoder, button and idle-power unit.
`timescale 1ns / 1ps

module tb_encoder_button_idle_power_unit;

    // A sample passes through the input register and then the result register,
    // and these spare cycles are enough to see the pipeline empty.
    localparam int PIPE_DRAIN  = 4;
    // Cycles with no transfer on either channel before the run is abandoned.
    // The longest legal quiet stretch is one long input gap plus one long
    // output stall.
    localparam int STALL_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;

    // Preset codes above the last table entry; the block treats them as off.
    localparam logic [ebip_pkg::PRESET_WIDTH-1:0] PRESET_SPARE_LO =
        ebip_pkg::PRESET_WIDTH'(5);
    localparam logic [ebip_pkg::PRESET_WIDTH-1:0] PRESET_SPARE_HI =
        ebip_pkg::PRESET_WIDTH'(7);
    // Register indexes that the block does not implement.
    localparam logic [ebip_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_A =
        ebip_pkg::CFG_INDEX_WIDTH'(2);
    localparam logic [ebip_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_B =
        ebip_pkg::CFG_INDEX_WIDTH'(3);

    // Every input of the block starts at a known value.
    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_ready;
    ebip_pkg::in_t                        in_data   = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    ebip_pkg::out_t                       out_data;
    logic                                 cfg_we    = 1'b0;
    logic [ebip_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [ebip_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

    encoder_button_idle_power_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the block's state and registers, advanced once per
    // accepted sample and once per register write.
    logic [1:0]                        m_ab;
    logic [ebip_pkg::COUNT_WIDTH-1:0]  m_count;
    logic [ebip_pkg::COUNT_WIDTH-1:0]  m_base;
    logic [1:0]                        m_level;       // bit 0 knob key, bit 1 user key
    logic [ebip_pkg::SINCE_WIDTH-1:0]  m_since [2];
    logic [ebip_pkg::IDLE_WIDTH-1:0]   m_idle;
    logic                              m_dim;
    logic [ebip_pkg::PRESET_WIDTH-1:0] m_preset;
    logic [7:0]                        m_debounce;

    ebip_pkg::out_t expected_results [$];
    ebip_pkg::out_t want_result;
    int   mismatch_count = 0;
    int   result_count   = 0;
    int   quiet_cycles   = 0;

    // When clear, neither side inserts gaps, so both channels run at full rate.
    bit   idling_on = 1'b1;

    // State of the random stimulus: raw key levels, how many more samples
    // each level is held, the direction the knob is being turned in, the
    // share of samples that carry a tick, and the longest key hold.
    logic [1:0] key_raw;
    int         key_run [2];
    int         turn_dir;
    int         tick_pct;
    int         key_run_max;

    // The A/B lines step through 00, 01, 11, 10; position = {a, a ^ b}. The
    // mapping is its own inverse, so it also turns a position into lines.
    // Moving one position forward counts down, one back counts up, two is
    // an illegal jump.
    function automatic logic [1:0] quad_position(input logic [1:0] ab);
        return {ab[1], ab[1] ^ ab[0]};
    endfunction

    // Work out the result of one sample and advance the shadow state.
    function automatic ebip_pkg::out_t predict_sample(input ebip_pkg::in_t s);
        ebip_pkg::out_t                   r;
        logic [1:0]                       cur;
        logic [1:0]                       hop;
        logic [1:0]                       raw;
        logic [1:0]                       press;
        logic [ebip_pkg::COUNT_WIDTH-1:0] diff;
        int         half;
        int         sleep_ms;
        int         dim_ms;
        bit         moved;
        bit         sleepy;

        cur   = {s.enc_a, s.enc_b};
        hop   = quad_position(cur) - quad_position(m_ab);
        moved = (hop == 2'd1) || (hop == 2'd3);
        if (hop == 2'd1)
            m_count = m_count - 1'b1;
        else if (hop == 2'd3)
            m_count = m_count + 1'b1;
        m_ab = cur;

        // Half the distance from the last detent, rounded toward zero.
        diff = m_count - m_base;
        half = $signed(diff) / 2;
        if (half > 1)
            half = 1;
        if (half < -1)
            half = -1;
        if (half != 0)
            m_base = m_base + ebip_pkg::COUNT_WIDTH'(half * 2);

        // Keys are only looked at on a tick.
        raw   = {s.user_key_down, s.knob_key_down};
        press = 2'b00;
        if (s.ms_tick)
        begin
            if (m_idle != ebip_pkg::IDLE_MAX)
                m_idle = m_idle + 1'b1;
            for (int k = 0; k < 2; k++)
            begin
                if (m_since[k] != {ebip_pkg::SINCE_WIDTH{1'b1}})
                    m_since[k] = m_since[k] + 1'b1;
                if (raw[k] != m_level[k] && m_since[k] >= m_debounce)
                begin
                    m_level[k] = raw[k];
                    m_since[k] = '0;
                    press[k]   = raw[k];
                end
            end
        end

        if (moved || press != 2'b00)
        begin
            m_idle = '0;
            m_dim  = 1'b0;
        end

        case (m_preset)
            ebip_pkg::PRESET_30S:  begin sleep_ms = 30000;  dim_ms = 20000;  end
            ebip_pkg::PRESET_1MIN: begin sleep_ms = 60000;  dim_ms = 40000;  end
            ebip_pkg::PRESET_2MIN: begin sleep_ms = 120000; dim_ms = 80000;  end
            ebip_pkg::PRESET_5MIN: begin sleep_ms = 300000; dim_ms = 200000; end
            default:               begin sleep_ms = 0;      dim_ms = 0;      end
        endcase
        // With sleep off the dim flag is left exactly as it was.
        sleepy = 1'b0;
        if (sleep_ms != 0)
        begin
            if (!m_dim && m_idle >= dim_ms)
                m_dim = 1'b1;
            sleepy = m_idle >= sleep_ms;
        end

        r.detent_step      = half[1:0];
        r.knob_press_event = press[0];
        r.user_press_event = press[1];
        r.knob_held        = m_level[0];
        r.user_held        = m_level[1];
        r.backlight_dim    = m_dim;
        r.sleep_request    = sleepy;
        return r;
    endfunction

    // Mostly no gap, sometimes a few cycles, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic ebip_pkg::in_t make_sample(input logic [1:0] ab, input logic knob,
                                                  input logic user, input logic tick);
        ebip_pkg::in_t s;
        s.enc_a         = ab[1];
        s.enc_b         = ab[0];
        s.knob_key_down = knob;
        s.user_key_down = user;
        s.ms_tick       = tick;
        return s;
    endfunction

    // A sample that leaves the encoder lines where they are.
    function automatic ebip_pkg::in_t keys_sample(input logic knob, input logic user,
                                                  input logic tick);
        return make_sample(m_ab, knob, user, tick);
    endfunction

    // A sample that turns the knob by one position with the keys released.
    function automatic ebip_pkg::in_t turn_sample();
        return make_sample(quad_position(quad_position(m_ab) + 2'd1), 1'b0, 1'b0, 1'b1);
    endfunction

    // Random sample: mostly the knob turning in runs and keys held long
    // enough to get through the debounce, with short bounces mixed in and a
    // small share of pure noise that also produces illegal line jumps.
    function automatic ebip_pkg::in_t next_random_sample();
        logic [1:0] p;
        int         r;

        p = quad_position(m_ab);
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            p       = 2'($urandom_range(0, 3));
            key_raw = 2'($urandom_range(0, 3));
        end
        else
        begin
            if ($urandom_range(0, 19) == 0)
                turn_dir = -turn_dir;
            if (r < 70)
                p = p + 2'(turn_dir);
            for (int k = 0; k < 2; k++)
            begin
                if (key_run[k] == 0)
                begin
                    key_raw[k] = ~key_raw[k];
                    if ($urandom_range(0, 3) == 0)
                        key_run[k] = $urandom_range(1, 3);
                    else
                        key_run[k] = $urandom_range(1, key_run_max);
                end
                else
                    key_run[k]--;
            end
        end
        return make_sample(quad_position(p), key_raw[0], key_raw[1],
                           $urandom_range(1, 100) <= tick_pct);
    endfunction

    // Offer one sample, hold it until the block takes it, then record the
    // result it must produce.
    task automatic send_sample(input ebip_pkg::in_t s);
        int gap;
        gap = idling_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(predict_sample(s));
    endtask

    // Stop offering samples and wait until every outstanding result is in.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // Registers change only with the pipeline empty.
    task automatic write_reg(input logic [ebip_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [ebip_pkg::CFG_DATA_WIDTH-1:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == ebip_pkg::REG_SLEEP_PRESET)
            m_preset = val[ebip_pkg::PRESET_WIDTH-1:0];
        else if (idx == ebip_pkg::REG_DEBOUNCE_MS)
            m_debounce = val;
    endtask

    // Samples with the keys released and the knob still, until the idle
    // time reaches the target. A few samples carry no tick.
    task automatic idle_until(input int target);
        while (m_idle < target)
            send_sample(keys_sample(1'b0, 1'b0, $urandom_range(0, 19) != 0));
    endtask

    task automatic run_random_phase(input int count, input int tick_share);
        tick_pct    = tick_share;
        key_run_max = 2 * int'(m_debounce) + 8;
        key_raw     = m_level;
        key_run[0]  = 0;
        key_run[1]  = 0;
        turn_dir    = 1;
        repeat (count) send_sample(next_random_sample());
    endtask

    // Full turns in both directions, a half step that goes back, and all
    // four illegal jumps. No sample carries a tick, so held keys must not
    // show up as presses.
    task automatic test_quadrature();
        send_sample(make_sample(2'b01, 1'b1, 1'b0, 1'b0));
        send_sample(make_sample(2'b11, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b10, 1'b0, 1'b1, 1'b0));
        send_sample(make_sample(2'b00, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b10, 1'b1, 1'b1, 1'b0));
        send_sample(make_sample(2'b11, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b01, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b00, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b01, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b00, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b11, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b00, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b01, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b10, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b01, 1'b0, 1'b0, 1'b0));
        send_sample(make_sample(2'b00, 1'b0, 1'b0, 1'b0));
    endtask

    // Random traffic on the settings the block comes out of reset with.
    task automatic test_reset_settings();
        run_random_phase(130, 80);
    endtask

    // With no debounce time a change is taken on the very next tick; with
    // one millisecond it needs one tick since the last accepted change.
    task automatic test_key_debounce();
        write_reg(ebip_pkg::REG_DEBOUNCE_MS, 8'd0);
        send_sample(keys_sample(1'b1, 1'b0, 1'b0));
        send_sample(keys_sample(1'b1, 1'b0, 1'b1));
        send_sample(keys_sample(1'b1, 1'b1, 1'b1));
        send_sample(keys_sample(1'b0, 1'b0, 1'b1));
        send_sample(keys_sample(1'b1, 1'b1, 1'b1));
        send_sample(keys_sample(1'b0, 1'b0, 1'b0));
        send_sample(keys_sample(1'b0, 1'b0, 1'b1));
        write_reg(ebip_pkg::REG_DEBOUNCE_MS, 8'd1);
        send_sample(keys_sample(1'b1, 1'b0, 1'b1));
        send_sample(keys_sample(1'b0, 1'b1, 1'b1));
        send_sample(keys_sample(1'b0, 1'b0, 1'b1));
        send_sample(keys_sample(1'b0, 1'b0, 1'b1));
    endtask

    // Idle timing runs at full rate on both sides: the idle time counting
    // across preset changes, the off and spare presets keeping the dim flag,
    // and activity clearing everything.
    task automatic test_idle_timer();
        idling_on = 1'b0;
        write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::PRESET_30S);
        send_sample(turn_sample());
        idle_until(24);
        // A knob press ends the idle period; its release is not activity.
        send_sample(keys_sample(1'b1, 1'b0, 1'b1));
        idle_until(12);

        write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::PRESET_5MIN);
        repeat (8) send_sample(keys_sample(1'b0, 1'b0, 1'b1));

        // Idle time keeps counting across the preset changes below.
        write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::PRESET_OFF);
        repeat (4) send_sample(keys_sample(1'b0, 1'b0, 1'b1));
        for (int p = PRESET_SPARE_LO; p <= PRESET_SPARE_HI; p++)
        begin
            write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::CFG_DATA_WIDTH'(p));
            repeat (3) send_sample(keys_sample(1'b0, 1'b0, 1'b1));
        end
        write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::PRESET_1MIN);
        repeat (3) send_sample(keys_sample(1'b0, 1'b0, 1'b0));
        write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::PRESET_2MIN);
        repeat (3) send_sample(keys_sample(1'b0, 1'b0, 1'b1));

        // Writes to unused indexes must change nothing.
        write_reg(REG_SPARE_A, ebip_pkg::CFG_DATA_WIDTH'($urandom_range(0, 255)));
        write_reg(REG_SPARE_B, ebip_pkg::CFG_DATA_WIDTH'($urandom_range(0, 255)));
        repeat (3) send_sample(keys_sample(1'b0, 1'b0, 1'b1));
        send_sample(turn_sample());
        repeat (5) send_sample(keys_sample(1'b0, 1'b0, 1'b1));
        idling_on = 1'b1;
    endtask

    // Random traffic over a spread of settings, including both debounce
    // extremes, the spare presets and one stretch with no idling at all.
    task automatic test_random_mix();
        write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::PRESET_1MIN);
        write_reg(ebip_pkg::REG_DEBOUNCE_MS, 8'd1);
        run_random_phase(180, 70);

        idling_on = 1'b0;
        write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::PRESET_OFF);
        write_reg(ebip_pkg::REG_DEBOUNCE_MS, 8'd255);
        run_random_phase(450, 95);
        idling_on = 1'b1;

        write_reg(ebip_pkg::REG_SLEEP_PRESET,
                  ebip_pkg::CFG_DATA_WIDTH'($urandom_range(PRESET_SPARE_LO,
                                                           PRESET_SPARE_HI)));
        write_reg(ebip_pkg::REG_DEBOUNCE_MS, 8'd0);
        run_random_phase(150, 50);

        write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::PRESET_5MIN);
        write_reg(ebip_pkg::REG_DEBOUNCE_MS, 8'd2);
        run_random_phase(150, 85);

        write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::PRESET_2MIN);
        write_reg(ebip_pkg::REG_DEBOUNCE_MS,
                  ebip_pkg::CFG_DATA_WIDTH'($urandom_range(3, 40)));
        run_random_phase(160, 90);

        write_reg(ebip_pkg::REG_SLEEP_PRESET, ebip_pkg::PRESET_30S);
        write_reg(ebip_pkg::REG_DEBOUNCE_MS,
                  ebip_pkg::CFG_DATA_WIDTH'($urandom_range(1, 12)));
        run_random_phase(150, 60);
    endtask

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic check_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
        if (got !== want)
            report_error($sformatf("result %0d: %s expected %b, got %b",
                                   result_count, name, want, got));
    endtask

    // Result side: random stalls, with runs of ready in between. Stalls stop
    // whenever the current test asks for full rate.
    initial
    begin
        int hold;
        int gap;
        @(posedge clk);
        forever
        begin
            hold = $urandom_range(1, 24);
            out_ready <= 1'b1;
            repeat (hold) @(posedge clk);
            gap = idling_on ? pick_gap() : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Every result transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_error($sformatf("result %0d: %h arrived with nothing expected",
                                       result_count, out_data));
            else
            begin
                want_result = expected_results.pop_front();
                check_field("detent_step", want_result.detent_step, out_data.detent_step);
                check_field("knob_press_event", want_result.knob_press_event,
                            out_data.knob_press_event);
                check_field("user_press_event", want_result.user_press_event,
                            out_data.user_press_event);
                check_field("knob_held", want_result.knob_held, out_data.knob_held);
                check_field("user_held", want_result.user_held, out_data.user_held);
                check_field("backlight_dim", want_result.backlight_dim,
                            out_data.backlight_dim);
                check_field("sleep_request", want_result.sleep_request,
                            out_data.sleep_request);
            end
            result_count++;
        end
    end

    // Watchdog: a long stretch with no transfer on either channel means the
    // block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        m_ab       = 2'b00;
        m_count    = '0;
        m_base     = '0;
        m_level    = 2'b00;
        m_since[0] = '0;
        m_since[1] = '0;
        m_idle     = '0;
        m_dim      = 1'b0;
        m_preset   = ebip_pkg::PRESET_OFF;
        m_debounce = ebip_pkg::DEBOUNCE_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_quadrature();
        test_reset_settings();
        test_key_debounce();
        test_idle_timer();
        test_random_mix();

        drain_results();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
